### sv/mscg_pkg.sv
// Shared constants and types of the multi-stop color gradient mapper.
package mscg_pkg;

    localparam int DEFAULT_MAX_STOPS = 8;

    localparam int VALUE_W    = 32;              // Q16.16 sample and bounds
    localparam int CH_W       = 8;               // one color channel
    localparam int NUM_CH     = 3;
    localparam int RGB_W      = CH_W * NUM_CH;
    localparam int NUM_W      = VALUE_W + CH_W;  // blend numerator
    localparam int SIDE_W     = 1 + RGB_W;       // direct flag and direct color
    localparam int COUNT_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // channel lanes, red in the high byte
    localparam int LANE_RED   = 2;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 0;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_BOUND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_BOUND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STOPS_01    = 3'd3;

    localparam logic [VALUE_W-1:0] LOWER_RESET = 32'h0000_0000;
    localparam logic [VALUE_W-1:0] UPPER_RESET = 32'h0001_0000;

    typedef enum logic [1:0] {
        CASE_BLACK,
        CASE_FIRST,
        CASE_LAST,
        CASE_BLEND
    } map_case_t;

    localparam int CASE_W = $bits(map_case_t);

endpackage

### sv/multi_stop_color_gradient_map.sv
// Top level of the multi-stop color gradient mapper: config, pipeline, output.
//
// Maps one signed Q16.16 sample per word to an 8-bit RGB color over up to
// MAX_STOPS evenly spaced stops between lower_bound and upper_bound, with
// exact integer interpolation. A new sample is taken every clock while
// sample_ready is high. The pipeline is built of two front stages
// (classify, scale the offset), one restoring step per bit of the stop index,
// two blend stages (products, sum), eight restoring steps for the channel
// quotient and the output register. The pipeline advances as one whole, so
// sample_ready drops only while a result sits unaccepted in the output
// register. Configuration is written through cfg_we / cfg_index / cfg_data
// while no word is in flight; indexes past the last register are ignored.
module multi_stop_color_gradient_map #(
    parameter int MAX_STOPS = mscg_pkg::DEFAULT_MAX_STOPS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mscg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mscg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  logic signed [mscg_pkg::VALUE_W-1:0] sample_value,
    output logic                                color_valid,
    input  logic                                color_ready,
    output logic [mscg_pkg::CH_W-1:0]           red,
    output logic [mscg_pkg::CH_W-1:0]           green,
    output logic [mscg_pkg::CH_W-1:0]           blue
);

    import mscg_pkg::*;

    localparam int CNT_W = $clog2(MAX_STOPS + 1);
    localparam int BIN_W = $clog2(MAX_STOPS);
    localparam int S_W   = VALUE_W + BIN_W;

    // configuration registers
    logic signed [VALUE_W-1:0]          lower_bound_reg;
    logic signed [VALUE_W-1:0]          upper_bound_reg;
    logic [COUNT_W-1:0]                 stop_count_reg;
    logic [MAX_STOPS-1:0][RGB_W-1:0]    stop_rgb_reg;
    logic [CNT_W-1:0]                   count_sat;

    // global advance: everything moves unless the output word is held
    logic en;

    // front
    logic             fr_valid;
    logic [S_W-1:0]   fr_s;
    logic [VALUE_W-1:0] fr_range;
    map_case_t        fr_case;

    // stop index division chain
    logic [BIN_W:0]             bin_valid;
    logic [0:0][S_W-1:0]        bin_rem  [BIN_W+1];
    logic [0:0][BIN_W-1:0]      bin_quo  [BIN_W+1];
    logic [VALUE_W-1:0]         bin_div  [BIN_W+1];
    logic [CASE_W-1:0]          bin_side [BIN_W+1];

    // blend
    logic                           bl_valid;
    logic [NUM_CH-1:0][NUM_W-1:0]   bl_num;
    logic [VALUE_W-1:0]             bl_range;
    logic                           bl_direct;
    logic [RGB_W-1:0]               bl_rgb;

    // channel division chain
    logic [CH_W:0]                  ch_valid;
    logic [NUM_CH-1:0][NUM_W-1:0]   ch_rem  [CH_W+1];
    logic [NUM_CH-1:0][CH_W-1:0]    ch_quo  [CH_W+1];
    logic [VALUE_W-1:0]             ch_div  [CH_W+1];
    logic [SIDE_W-1:0]              ch_side [CH_W+1];

    // output register
    logic               color_valid_reg;
    logic [CH_W-1:0]    red_reg, green_reg, blue_reg;
    logic [CH_W-1:0]    red_next, green_next, blue_next;
    logic               out_direct;
    logic [RGB_W-1:0]   out_rgb;

    //------------------------------------------------------------------
    // configuration
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_bound_reg <= LOWER_RESET;
            upper_bound_reg <= UPPER_RESET;
            stop_count_reg  <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_LOWER_BOUND)
                lower_bound_reg <= cfg_data[VALUE_W-1:0];
            if (cfg_index == REG_UPPER_BOUND)
                upper_bound_reg <= cfg_data[VALUE_W-1:0];
            if (cfg_index == REG_STOP_COUNT)
                stop_count_reg <= cfg_data[COUNT_W-1:0];
        end
    end

    // each stops register carries an even stop low and the next odd stop high
    for (genvar i = 0; i < MAX_STOPS; i++)
    begin : g_stop
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stop_rgb_reg[i] <= '0;
            end
            else if (cfg_we && cfg_index == REG_STOPS_01 + CFG_IDX_W'(i / 2))
            begin
                stop_rgb_reg[i] <= cfg_data[(i % 2) * RGB_W +: RGB_W];
            end
        end
    end

    // counts above the stop capacity saturate
    always_comb
    begin
        if (stop_count_reg > COUNT_W'(MAX_STOPS))
            count_sat = CNT_W'(MAX_STOPS);
        else
            count_sat = CNT_W'(stop_count_reg);
    end

    assign en           = !color_valid_reg || color_ready;
    assign sample_ready = en;

    //------------------------------------------------------------------
    // pipeline
    //------------------------------------------------------------------
    mscg_front #(
        .MAX_STOPS (MAX_STOPS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sample_valid),
        .sample    (sample_value),
        .lower     (lower_bound_reg),
        .upper     (upper_bound_reg),
        .count_sat (count_sat),
        .out_valid (fr_valid),
        .out_s     (fr_s),
        .out_range (fr_range),
        .out_case  (fr_case)
    );

    // stop index = floor(s / range), remainder is the blend fraction
    assign bin_valid[0]  = fr_valid;
    assign bin_rem[0][0] = fr_s;
    assign bin_quo[0]    = '0;
    assign bin_div[0]    = fr_range;
    assign bin_side[0]   = fr_case;

    for (genvar j = 0; j < BIN_W; j++)
    begin : g_bin
        mscg_div_stage #(
            .LANES  (1),
            .REM_W  (S_W),
            .DIV_W  (VALUE_W),
            .Q_W    (BIN_W),
            .SHIFT  (BIN_W - 1 - j),
            .SIDE_W (CASE_W)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (bin_valid[j]),
            .in_rem    (bin_rem[j]),
            .in_quo    (bin_quo[j]),
            .in_div    (bin_div[j]),
            .in_side   (bin_side[j]),
            .out_valid (bin_valid[j+1]),
            .out_rem   (bin_rem[j+1]),
            .out_quo   (bin_quo[j+1]),
            .out_div   (bin_div[j+1]),
            .out_side  (bin_side[j+1])
        );
    end

    // fraction is below range (< 2^32) whenever it is used
    mscg_blend #(
        .MAX_STOPS (MAX_STOPS)
    ) u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (bin_valid[BIN_W]),
        .in_bin     (bin_quo[BIN_W][0]),
        .in_frac    (bin_rem[BIN_W][0][VALUE_W-1:0]),
        .in_range   (bin_div[BIN_W]),
        .in_case    (map_case_t'(bin_side[BIN_W])),
        .count_sat  (count_sat),
        .stops      (stop_rgb_reg),
        .out_valid  (bl_valid),
        .out_num    (bl_num),
        .out_range  (bl_range),
        .out_direct (bl_direct),
        .out_rgb    (bl_rgb)
    );

    // channel = floor(numerator / range), numerator below 256 * range
    assign ch_valid[0] = bl_valid;
    assign ch_rem[0]   = bl_num;
    assign ch_quo[0]   = '0;
    assign ch_div[0]   = bl_range;
    assign ch_side[0]  = {bl_direct, bl_rgb};

    for (genvar j = 0; j < CH_W; j++)
    begin : g_chan
        mscg_div_stage #(
            .LANES  (NUM_CH),
            .REM_W  (NUM_W),
            .DIV_W  (VALUE_W),
            .Q_W    (CH_W),
            .SHIFT  (CH_W - 1 - j),
            .SIDE_W (SIDE_W)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (ch_valid[j]),
            .in_rem    (ch_rem[j]),
            .in_quo    (ch_quo[j]),
            .in_div    (ch_div[j]),
            .in_side   (ch_side[j]),
            .out_valid (ch_valid[j+1]),
            .out_rem   (ch_rem[j+1]),
            .out_quo   (ch_quo[j+1]),
            .out_div   (ch_div[j+1]),
            .out_side  (ch_side[j+1])
        );
    end

    //------------------------------------------------------------------
    // output register: special cases bypass the interpolated channels
    //------------------------------------------------------------------
    always_comb
    begin
        out_direct = ch_side[CH_W][RGB_W];
        out_rgb    = ch_side[CH_W][RGB_W-1:0];
        if (out_direct)
        begin
            red_next   = out_rgb[LANE_RED*CH_W   +: CH_W];
            green_next = out_rgb[LANE_GREEN*CH_W +: CH_W];
            blue_next  = out_rgb[LANE_BLUE*CH_W  +: CH_W];
        end
        else
        begin
            red_next   = ch_quo[CH_W][LANE_RED];
            green_next = ch_quo[CH_W][LANE_GREEN];
            blue_next  = ch_quo[CH_W][LANE_BLUE];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            color_valid_reg <= ch_valid[CH_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign color_valid = color_valid_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;

    //------------------------------------------------------------------
    // assertions
    //------------------------------------------------------------------
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable({bin_valid, ch_valid, color_valid_reg}))
        else $error("pipeline valids moved during a stall");

    a_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (bin_valid[BIN_W] && map_case_t'(bin_side[BIN_W]) == CASE_BLEND)
        |-> (bin_quo[BIN_W][0] <= BIN_W'(MAX_STOPS - 2)))
        else $error("stop index beyond last blend pair");

    a_frac_below_range: assert property (@(posedge clk) disable iff (!rst_n)
        (bin_valid[BIN_W] && map_case_t'(bin_side[BIN_W]) == CASE_BLEND)
        |-> (bin_rem[BIN_W][0] < S_W'(bin_div[BIN_W])))
        else $error("blend fraction not below range");

    a_chan_rem_below_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ch_valid[CH_W] && !ch_side[CH_W][RGB_W])
        |-> (ch_rem[CH_W][LANE_RED]   < NUM_W'(ch_div[CH_W]))
         && (ch_rem[CH_W][LANE_GREEN] < NUM_W'(ch_div[CH_W]))
         && (ch_rem[CH_W][LANE_BLUE]  < NUM_W'(ch_div[CH_W])))
        else $error("channel quotient overflowed eight bits");

endmodule

### sv/mscg_div_stage.sv
// One registered restoring-division step, shared divisor over several lanes.
module mscg_div_stage #(
    parameter int LANES  = 1,
    parameter int REM_W  = 8,
    parameter int DIV_W  = 8,
    parameter int Q_W    = 1,
    parameter int SHIFT  = 0,
    parameter int SIDE_W = 1,
    localparam int CMP_W = (REM_W > DIV_W + SHIFT) ? REM_W : DIV_W + SHIFT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [LANES-1:0][REM_W-1:0] in_rem,
    input  logic [LANES-1:0][Q_W-1:0]   in_quo,
    input  logic [DIV_W-1:0]            in_div,
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    output logic [LANES-1:0][REM_W-1:0] out_rem,
    output logic [LANES-1:0][Q_W-1:0]   out_quo,
    output logic [DIV_W-1:0]            out_div,
    output logic [SIDE_W-1:0]           out_side
);

    logic                        valid_reg;
    logic [LANES-1:0][REM_W-1:0] rem_reg, rem_next;
    logic [LANES-1:0][Q_W-1:0]   quo_reg, quo_next;
    logic [DIV_W-1:0]            div_reg;
    logic [SIDE_W-1:0]           side_reg;
    logic [CMP_W-1:0]            trial;
    logic [CMP_W-1:0]            rem_ext [LANES];

    always_comb
    begin
        trial = CMP_W'(in_div) << SHIFT;
        for (int l = 0; l < LANES; l++)
        begin
            rem_ext[l] = CMP_W'(in_rem[l]);
            if (rem_ext[l] >= trial)
            begin
                rem_next[l] = REM_W'(rem_ext[l] - trial);
                quo_next[l] = in_quo[l] | (Q_W'(1) << SHIFT);
            end
            else
            begin
                rem_next[l] = in_rem[l];
                quo_next[l] = in_quo[l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            div_reg  <= in_div;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

endmodule

### sv/mscg_front.sv
// Front stages: case classification, offset and range, then scaled offset.
module mscg_front #(
    parameter int MAX_STOPS = mscg_pkg::DEFAULT_MAX_STOPS,
    localparam int CNT_W = $clog2(MAX_STOPS + 1),
    localparam int BIN_W = $clog2(MAX_STOPS),
    localparam int S_W   = mscg_pkg::VALUE_W + BIN_W
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [mscg_pkg::VALUE_W-1:0] sample,
    input  logic signed [mscg_pkg::VALUE_W-1:0] lower,
    input  logic signed [mscg_pkg::VALUE_W-1:0] upper,
    input  logic [CNT_W-1:0]                   count_sat,
    output logic                               out_valid,
    output logic [S_W-1:0]                     out_s,
    output logic [mscg_pkg::VALUE_W-1:0]       out_range,
    output mscg_pkg::map_case_t                out_case
);

    import mscg_pkg::*;

    logic [VALUE_W:0]   d_wide;
    logic [VALUE_W:0]   range_wide;
    map_case_t          case_next;

    logic               s1_valid_reg;
    logic [VALUE_W-1:0] s1_d_reg;
    logic [VALUE_W-1:0] s1_range_reg;
    logic [BIN_W-1:0]   s1_cm1_reg;
    map_case_t          s1_case_reg;

    logic               s2_valid_reg;
    logic [S_W-1:0]     s2_s_reg;
    logic [VALUE_W-1:0] s2_range_reg;
    map_case_t          s2_case_reg;

    always_comb
    begin
        d_wide     = {sample[VALUE_W-1], sample} - {lower[VALUE_W-1], lower};
        range_wide = {upper[VALUE_W-1], upper} - {lower[VALUE_W-1], lower};
        priority if (count_sat == '0)
            case_next = CASE_BLACK;
        else if (count_sat == CNT_W'(1) || sample <= lower || upper == lower)
            case_next = CASE_FIRST;
        else if (sample >= upper)
            case_next = CASE_LAST;
        else
            case_next = CASE_BLEND;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // in the blend case lower < sample < upper, so both differences fit 32 bits
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_d_reg     <= d_wide[VALUE_W-1:0];
            s1_range_reg <= range_wide[VALUE_W-1:0];
            s1_cm1_reg   <= BIN_W'(count_sat - CNT_W'(1));
            s1_case_reg  <= case_next;
            s2_s_reg     <= S_W'(s1_d_reg) * S_W'(s1_cm1_reg);
            s2_range_reg <= s1_range_reg;
            s2_case_reg  <= s1_case_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_s     = s2_s_reg;
    assign out_range = s2_range_reg;
    assign out_case  = s2_case_reg;

endmodule

### sv/mscg_blend.sv
// Blend stages: stop pair lookup, channel products, numerator sum.
module mscg_blend #(
    parameter int MAX_STOPS = mscg_pkg::DEFAULT_MAX_STOPS,
    localparam int CNT_W  = $clog2(MAX_STOPS + 1),
    localparam int BIN_W  = $clog2(MAX_STOPS),
    localparam int PAIR_W = (MAX_STOPS > 2) ? $clog2(MAX_STOPS - 1) : 1,
    localparam int PAIR_D = 2 ** PAIR_W
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              en,
    input  logic                                              in_valid,
    input  logic [BIN_W-1:0]                                  in_bin,
    input  logic [mscg_pkg::VALUE_W-1:0]                      in_frac,
    input  logic [mscg_pkg::VALUE_W-1:0]                      in_range,
    input  mscg_pkg::map_case_t                               in_case,
    input  logic [CNT_W-1:0]                                  count_sat,
    input  logic [MAX_STOPS-1:0][mscg_pkg::RGB_W-1:0]         stops,
    output logic                                              out_valid,
    output logic [mscg_pkg::NUM_CH-1:0][mscg_pkg::NUM_W-1:0]  out_num,
    output logic [mscg_pkg::VALUE_W-1:0]                      out_range,
    output logic                                              out_direct,
    output logic [mscg_pkg::RGB_W-1:0]                        out_rgb
);

    import mscg_pkg::*;

    // pair k holds stop k (low) and stop k+1 (high)
    logic [RGB_W-1:0]   pair_lo [PAIR_D];
    logic [RGB_W-1:0]   pair_hi [PAIR_D];
    logic [PAIR_W-1:0]  idx;
    logic [RGB_W-1:0]   c1, c2;
    logic [RGB_W-1:0]   rgb_next;
    logic [VALUE_W-1:0] inv_frac;
    logic [NUM_CH-1:0][NUM_W-1:0] pa_next, pb_next;

    logic               a_valid_reg;
    logic [NUM_CH-1:0][NUM_W-1:0] a_pa_reg, a_pb_reg;
    logic [VALUE_W-1:0] a_range_reg;
    logic               a_direct_reg;
    logic [RGB_W-1:0]   a_rgb_reg;

    logic               b_valid_reg;
    logic [NUM_CH-1:0][NUM_W-1:0] b_num_reg;
    logic [VALUE_W-1:0] b_range_reg;
    logic               b_direct_reg;
    logic [RGB_W-1:0]   b_rgb_reg;

    for (genvar k = 0; k < PAIR_D; k++)
    begin : g_pair
        if (k < MAX_STOPS - 1)
        begin : g_used
            assign pair_lo[k] = stops[k];
            assign pair_hi[k] = stops[k+1];
        end
        else
        begin : g_unused
            assign pair_lo[k] = '0;
            assign pair_hi[k] = '0;
        end
    end

    always_comb
    begin
        unique case (in_case)
            CASE_LAST:              idx = PAIR_W'(count_sat - CNT_W'(2));
            CASE_BLEND:             idx = PAIR_W'(in_bin);
            CASE_BLACK, CASE_FIRST: idx = '0;
        endcase
        c1 = pair_lo[idx];
        c2 = pair_hi[idx];
        unique case (in_case)
            CASE_BLACK:             rgb_next = '0;
            CASE_LAST:              rgb_next = c2;
            CASE_FIRST, CASE_BLEND: rgb_next = c1;
        endcase
        inv_frac = in_range - in_frac;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            pa_next[ch] = NUM_W'(c1[ch*CH_W +: CH_W]) * NUM_W'(inv_frac);
            pb_next[ch] = NUM_W'(c2[ch*CH_W +: CH_W]) * NUM_W'(in_frac);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_pa_reg     <= pa_next;
            a_pb_reg     <= pb_next;
            a_range_reg  <= in_range;
            a_direct_reg <= (in_case != CASE_BLEND);
            a_rgb_reg    <= rgb_next;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                b_num_reg[ch] <= a_pa_reg[ch] + a_pb_reg[ch];
            end
            b_range_reg  <= a_range_reg;
            b_direct_reg <= a_direct_reg;
            b_rgb_reg    <= a_rgb_reg;
        end
    end

    assign out_valid  = b_valid_reg;
    assign out_num    = b_num_reg;
    assign out_range  = b_range_reg;
    assign out_direct = b_direct_reg;
    assign out_rgb    = b_rgb_reg;

endmodule
